// ----- sv/mkd_pkg.sv -----
package mkd_pkg;

	localparam int CFG_W    = 16;
	localparam int IDX_W    = 1;
	localparam int TOTAL_W  = 6;
	localparam int LETTER_W = 5;
	localparam int LETTERS  = 26;
	localparam int PAT_W    = 8;
	localparam int LEN_W    = 3;

	localparam logic [IDX_W-1:0] REG_LOCKOUT = 1'b0;
	localparam logic [IDX_W-1:0] REG_DASH    = 1'b1;

	localparam logic [CFG_W-1:0] LOCKOUT_RST = 16'd50;
	localparam logic [CFG_W-1:0] DASH_RST    = 16'd200;

	typedef struct packed {
		logic key_down;
		logic erase_down;
		logic decode_down;
	} tick_t;

	typedef struct packed {
		logic                element_added;
		logic                element_is_dash;
		logic [TOTAL_W-1:0]  element_total;
		logic                decode_done;
		logic                letter_found;
		logic [LETTER_W-1:0] letter_index;
		logic                cleared;
	} result_t;

	typedef struct packed {
		logic [CFG_W-1:0] lockout_ticks;
		logic [CFG_W-1:0] dash_ticks;
	} cfg_t;

	typedef struct packed {
		logic                found;
		logic [LETTER_W-1:0] index;
	} match_t;

	// Morse code per letter: length, and pattern with the first element in the
	// highest used bit, where a one is a dash.
	localparam logic [LEN_W-1:0] CODE_LEN [LETTERS] = '{
		3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
		3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
	};

	localparam logic [3:0] CODE_BITS [LETTERS] = '{
		4'd1, 4'd8, 4'd10, 4'd4, 4'd0, 4'd2, 4'd6, 4'd0, 4'd0, 4'd7, 4'd5, 4'd4, 4'd3,
		4'd2, 4'd7, 4'd6, 4'd13, 4'd2, 4'd0, 4'd1, 4'd1, 4'd1, 4'd3, 4'd9, 4'd11, 4'd12
	};

	function automatic match_t morse_match(logic [PAT_W-1:0] pat, logic [LEN_W-1:0] len);
		match_t m;
		m = '0;
		for (int i = LETTERS - 1; i >= 0; i--) begin
			if (CODE_LEN[i] == len && PAT_W'(CODE_BITS[i]) == pat) begin
				m.found = 1'b1;
				m.index = LETTER_W'(i);
			end
		end
		return m;
	endfunction

endpackage

// ----- sv/mkd_chan_if.sv -----
interface mkd_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/morse_key_letter_decoder_core.sv -----
// Morse key letter decoder. Each tick transaction carries the key, erase and
// decode button levels and yields exactly one result transaction. A tick sits
// in a two-entry input queue and is executed at its head once the result
// register is empty or being taken; the result is registered. One tick per
// clock is sustained while results are taken, with the lockout and hold
// counters, the element pattern and the constant letter table all handled
// in the execute unit. Only the first MAX_CODE_LENGTH elements are kept as a
// pattern; longer runs are counted and decode to no letter.
// Write the registers only while no transaction is in flight.
module morse_key_letter_decoder_core
	import mkd_pkg::*;
#(
	parameter int MAX_ELEMENTS    = 49,
	parameter int MAX_CODE_LENGTH = 5,
	parameter int COUNTER_WIDTH   = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	mkd_chan_if.sink         tick,
	mkd_chan_if.source       result,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	cfg_t  cfg_q;
	logic  q_valid;
	tick_t q_data;
	logic  q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lockout_ticks <= LOCKOUT_RST;
			cfg_q.dash_ticks    <= DASH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOCKOUT: cfg_q.lockout_ticks <= cfg_data;
				REG_DASH:    cfg_q.dash_ticks    <= cfg_data;
				default:     cfg_q               <= cfg_q;
			endcase
		end
	end

	mkd_in_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop)
	);

	mkd_exec #(
		.MAX_ELEMENTS    (MAX_ELEMENTS),
		.MAX_CODE_LENGTH (MAX_CODE_LENGTH),
		.COUNTER_WIDTH   (COUNTER_WIDTH)
	) u_exec (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.result  (result)
	);

endmodule

// ----- sv/mkd_in_queue.sv -----
module mkd_in_queue
	import mkd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	mkd_chan_if.sink    tick,
	output logic        q_valid,
	output tick_t       q_data,
	input  logic        q_pop
);

	tick_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign tick.ready = (cnt_q != 2'd2);
	assign q_valid    = (cnt_q != 2'd0);
	assign q_data     = mem_q[rd_ptr_q];
	assign push       = tick.valid && tick.ready;
	assign pop        = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= tick.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- sv/mkd_exec.sv -----
module mkd_exec
	import mkd_pkg::*;
#(
	parameter int MAX_ELEMENTS    = 49,
	parameter int MAX_CODE_LENGTH = 5,
	parameter int COUNTER_WIDTH   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_valid,
	input  tick_t       q_data,
	output logic        q_pop,
	mkd_chan_if.source  result
);

	localparam int CMP_W = (COUNTER_WIDTH > CFG_W) ? COUNTER_WIDTH : CFG_W;
	localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

	logic [COUNTER_WIDTH-1:0]   since_q, since_n;
	logic [COUNTER_WIDTH-1:0]   hold_q, hold_n, hold_base;
	logic                       held_q, held_n;
	logic [TOTAL_W-1:0]         count_q, count_n;
	logic [MAX_CODE_LENGTH-1:0] pat_q, pat_n;
	logic                       lvalid_q, lvalid_n;
	logic [LETTER_W-1:0]        lvalue_q, lvalue_n;
	logic                       open, acted, added, is_dash, done, clr, fire;
	match_t                     m;

	assign fire  = q_valid && (!result.valid || result.ready);
	assign q_pop = fire;
	assign open  = CMP_W'(since_q) >= CMP_W'(cfg.lockout_ticks);
	assign m     = morse_match(PAT_W'(pat_q), LEN_W'(count_q));

	always_comb begin
		held_n    = held_q;
		count_n   = count_q;
		pat_n     = pat_q;
		lvalid_n  = lvalid_q;
		lvalue_n  = lvalue_q;
		hold_base = hold_q;
		acted     = 1'b0;
		added     = 1'b0;
		is_dash   = 1'b0;
		done      = 1'b0;
		clr       = 1'b0;
		if (open) begin
			if (q_data.decode_down) begin
				lvalid_n = (count_q != '0) && (count_q <= TOTAL_W'(MAX_CODE_LENGTH)) && m.found;
				lvalue_n = lvalid_n ? m.index : '0;
				done     = 1'b1;
				acted    = 1'b1;
			end else if (q_data.key_down && !held_q) begin
				held_n    = 1'b1;
				hold_base = '0;
				acted     = 1'b1;
			end else if (!q_data.key_down && held_q) begin
				held_n = 1'b0;
				acted  = 1'b1;
				if (count_q < TOTAL_W'(MAX_ELEMENTS)) begin
					is_dash = CMP_W'(hold_q) >= CMP_W'(cfg.dash_ticks);
					if (count_q == '0) begin
						pat_n = MAX_CODE_LENGTH'(is_dash);
					end else if (count_q < TOTAL_W'(MAX_CODE_LENGTH)) begin
						pat_n = {pat_q[MAX_CODE_LENGTH-2:0], is_dash};
					end
					count_n = count_q + TOTAL_W'(1);
					added   = 1'b1;
				end
			end else if (q_data.erase_down) begin
				count_n  = '0;
				lvalid_n = 1'b0;
				lvalue_n = '0;
				clr      = 1'b1;
				acted    = 1'b1;
			end
		end
		if (acted) begin
			since_n = COUNTER_WIDTH'(1);
		end else begin
			since_n = (since_q == CNT_MAX) ? since_q : since_q + COUNTER_WIDTH'(1);
		end
		if (held_n) begin
			hold_n = (hold_base == CNT_MAX) ? hold_base : hold_base + COUNTER_WIDTH'(1);
		end else begin
			hold_n = hold_base;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pat_q                       <= pat_n;
			result.data.element_added   <= added;
			result.data.element_is_dash <= is_dash;
			result.data.element_total   <= count_n;
			result.data.decode_done     <= done;
			result.data.letter_found    <= lvalid_n;
			result.data.letter_index    <= lvalue_n;
			result.data.cleared         <= clr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_q      <= '0;
			hold_q       <= '0;
			held_q       <= 1'b0;
			count_q      <= '0;
			lvalid_q     <= 1'b0;
			lvalue_q     <= '0;
			result.valid <= 1'b0;
		end else begin
			if (fire) begin
				since_q      <= since_n;
				hold_q       <= hold_n;
				held_q       <= held_n;
				count_q      <= count_n;
				lvalid_q     <= lvalid_n;
				lvalue_q     <= lvalue_n;
				result.valid <= 1'b1;
			end else if (result.ready) begin
				result.valid <= 1'b0;
			end
		end
	end

endmodule
